@@ src/sctt_pkg.sv @@
package sctt_pkg;

    // Widths of the word fields
    localparam int unsigned MAX_GATE_INPUTS = 6;
    localparam int unsigned COUNT_W         = 3;
    localparam int unsigned CUBE_W          = 6;
    localparam int unsigned TABLE_W         = 64;
    localparam int unsigned S_TDATA_W       = 16;
    localparam int unsigned S_TUSER_W       = 2;
    localparam int unsigned QUEUE_DEPTH     = 2;
    localparam int unsigned QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    // Bit positions inside s_tuser
    localparam int unsigned TUSER_FIRST = 0;
    localparam int unsigned TUSER_HAS   = 1;

    // Reset value of max_inputs
    localparam logic [COUNT_W-1:0] MAX_INPUTS_RESET = COUNT_W'(MAX_GATE_INPUTS);

    // One classified row, passed from front to back
    typedef struct packed {
        logic [COUNT_W-1:0] gate_n;    // input count in force for this row
        logic [CUBE_W-1:0]  care;      // care mask, positions >= n already cleared
        logic [CUBE_W-1:0]  value;
        logic               out_zero;
        logic               first;
        logic               last;
        logic               has;
        logic               kept;      // gate within both input limits
    } cube_op_t;

    // Queue push from the front end
    typedef struct packed {
        logic     push;
        cube_op_t op;
    } front_push_t;

    // Care positions that exist for an n-input gate
    function automatic logic [CUBE_W-1:0] pos_mask(input logic [COUNT_W-1:0] n);
        logic [CUBE_W:0] full;
        full = '0;
        if (n >= COUNT_W'(CUBE_W)) begin
            return '1;
        end
        full = (CUBE_W+1)'(1) << n;
        return CUBE_W'(full - (CUBE_W+1)'(1));
    endfunction

    // Minterms that exist for an n-input gate
    function automatic logic [TABLE_W-1:0] minterm_mask(input logic [COUNT_W-1:0] n);
        logic [TABLE_W-1:0] m;
        m = '1;
        case (n)
            3'd0:    m = TABLE_W'(64'h1);
            3'd1:    m = TABLE_W'(64'h3);
            3'd2:    m = TABLE_W'(64'hF);
            3'd3:    m = TABLE_W'(64'hFF);
            3'd4:    m = TABLE_W'(64'hFFFF);
            3'd5:    m = TABLE_W'(64'hFFFF_FFFF);
            default: m = '1;
        endcase
        return m;
    endfunction

    // All minterms covered by one cube, each checked on its own
    function automatic logic [TABLE_W-1:0] cube_hits(input logic [CUBE_W-1:0] care,
                                                     input logic [CUBE_W-1:0] value);
        logic [TABLE_W-1:0] hits;
        hits = '0;
        for (int m = 0; m < TABLE_W; m++) begin
            hits[m] = (((CUBE_W'(m)) ^ value) & care) == '0;
        end
        return hits;
    endfunction

endpackage

@@ src/sop_cover_to_truth_table.sv @@
// Builds the 64-bit truth table of one sum-of-products gate from its cover rows,
// one cube per input word, and returns one word per gate on its last row. Rows
// stream at one word per clock unless the two-entry queue is full or a last row
// waits for the output register: each cube is matched against all 64 minterms
// at once and folded into the table in the back-end stage. The last row is
// classified into a two-entry queue, then folded into the output register.
// The gate's polarity comes from the first row that carries a cube; a gate with
// no cube gives zero, and a gate wider than max_inputs (cfg port, reset 6) or 6
// returns gate_kept = 0 with a zero table. Write cfg only while the block is idle.
module sop_cover_to_truth_table (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [sctt_pkg::COUNT_W-1:0]    cfg_wdata,     // max_inputs
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // num_inputs[2:0], cube_care[8:3], cube_value[14:9], row_output_zero[15]
    input  logic [sctt_pkg::S_TDATA_W-1:0]  s_tdata,
    // first_row[0], has_row[1]
    input  logic [sctt_pkg::S_TUSER_W-1:0]  s_tuser,
    input  logic                            s_tlast,       // last_row
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // truth_table[63:0]
    output logic [sctt_pkg::TABLE_W-1:0]    m_tdata,
    // gate_kept[0]
    output logic                            m_tuser
);

    logic [sctt_pkg::COUNT_W-1:0] max_inputs_reg;
    sctt_pkg::front_push_t        fp;
    sctt_pkg::cube_op_t           head;
    logic                         q_full, q_not_empty, q_pop;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_inputs_reg <= sctt_pkg::MAX_INPUTS_RESET;
        end else if (cfg_we) begin
            max_inputs_reg <= cfg_wdata;
        end
    end

    sctt_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .max_inputs (max_inputs_reg),
        .queue_full (q_full),
        .fp         (fp)
    );

    sctt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fp        (fp),
        .full      (q_full),
        .not_empty (q_not_empty),
        .pop       (q_pop),
        .head      (head)
    );

    sctt_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op_valid (q_not_empty),
        .op       (head),
        .op_pop   (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

@@ src/sctt_front.sv @@
module sctt_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [sctt_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic [sctt_pkg::S_TUSER_W-1:0]    s_tuser,
    input  logic                              s_tlast,
    input  logic [sctt_pkg::COUNT_W-1:0]      max_inputs,
    input  logic                              queue_full,
    output sctt_pkg::front_push_t             fp
);

    logic [sctt_pkg::COUNT_W-1:0] gate_n_reg, gate_n_next;
    logic [sctt_pkg::COUNT_W-1:0] word_n, eff_n;
    logic [sctt_pkg::CUBE_W-1:0]  word_care, word_value;
    logic                         word_first, accept;

    // Unpack the word
    assign word_n     = s_tdata[2:0];
    assign word_care  = s_tdata[8:3];
    assign word_value = s_tdata[14:9];
    assign word_first = s_tuser[sctt_pkg::TUSER_FIRST];

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;

    // Input count in force: loaded on a first row, held otherwise
    assign eff_n       = word_first ? word_n : gate_n_reg;
    assign gate_n_next = accept ? eff_n : gate_n_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gate_n_reg <= '0;
        end else begin
            gate_n_reg <= gate_n_next;
        end
    end

    // Classify the row
    always_comb begin
        fp.push        = accept;
        fp.op.gate_n   = eff_n;
        fp.op.care     = word_care & sctt_pkg::pos_mask(eff_n);
        fp.op.value    = word_value;
        fp.op.out_zero = s_tdata[15];
        fp.op.first    = word_first;
        fp.op.last     = s_tlast;
        fp.op.has      = s_tuser[sctt_pkg::TUSER_HAS];
        fp.op.kept     = (eff_n <= max_inputs) &&
                         (eff_n <= sctt_pkg::COUNT_W'(sctt_pkg::MAX_GATE_INPUTS));
    end

endmodule

@@ src/sctt_queue.sv @@
module sctt_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sctt_pkg::front_push_t fp,
    output logic                  full,
    output logic                  not_empty,
    input  logic                  pop,
    output sctt_pkg::cube_op_t    head
);

    sctt_pkg::cube_op_t            entries_reg [sctt_pkg::QUEUE_DEPTH];
    logic [sctt_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [sctt_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [sctt_pkg::QCNT_W-1:0]   count_reg, count_next;
    logic                          do_pop;

    assign full      = count_reg == sctt_pkg::QCNT_W'(sctt_pkg::QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign do_pop    = pop && not_empty;
    assign head      = entries_reg[rd_ptr_reg];

    // Pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (fp.push) begin
            wr_ptr_next = (wr_ptr_reg == sctt_pkg::QPTR_W'(sctt_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == sctt_pkg::QPTR_W'(sctt_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (fp.push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!fp.push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge aclk) begin
        if (fp.push) begin
            entries_reg[wr_ptr_reg] <= fp.op;
        end
    end

endmodule

@@ src/sctt_back.sv @@
module sctt_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            op_valid,
    input  sctt_pkg::cube_op_t              op,
    output logic                            op_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sctt_pkg::TABLE_W-1:0]    m_tdata,
    output logic                            m_tuser
);

    logic [sctt_pkg::TABLE_W-1:0] acc_reg, acc_next;
    logic                         pol_reg, pol_next;
    logic                         seen_reg, seen_next;
    logic                         out_valid_reg, out_valid_next;
    logic [sctt_pkg::TABLE_W-1:0] out_table_reg, out_table_next;
    logic                         out_kept_reg, out_kept_next;

    logic [sctt_pkg::TABLE_W-1:0] acc_w, hits;
    logic                         pol_w, seen_w, out_free;

    // A last row needs the output register free, other rows never stall
    assign out_free = !out_valid_reg || m_tready;
    assign op_pop   = op_valid && (!op.last || out_free);
    assign hits     = sctt_pkg::cube_hits(op.care, op.value);

    // Fold the cube into the table
    always_comb begin
        acc_w  = op.first ? '0   : acc_reg;
        pol_w  = op.first ? 1'b0 : pol_reg;
        seen_w = op.first ? 1'b0 : seen_reg;
        if (op.has) begin
            if (!seen_w) begin
                pol_w  = op.out_zero;
                acc_w  = op.out_zero ? '1 : '0;
                seen_w = 1'b1;
            end
            acc_w = pol_w ? (acc_w & ~hits) : (acc_w | hits);
        end
    end

    // Gate state and output register
    always_comb begin
        acc_next       = acc_reg;
        pol_next       = pol_reg;
        seen_next      = seen_reg;
        out_table_next = out_table_reg;
        out_kept_next  = out_kept_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (op_pop) begin
            if (op.last) begin
                acc_next       = '0;
                pol_next       = 1'b0;
                seen_next      = 1'b0;
                out_valid_next = 1'b1;
                out_kept_next  = op.kept;
                out_table_next = (op.kept && seen_w) ?
                                 (acc_w & sctt_pkg::minterm_mask(op.gate_n)) : '0;
            end else begin
                acc_next  = acc_w;
                pol_next  = pol_w;
                seen_next = seen_w;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            pol_reg       <= 1'b0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            acc_reg       <= acc_next;
            pol_reg       <= pol_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_table_reg <= out_table_next;
        out_kept_reg  <= out_kept_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_table_reg;
    assign m_tuser  = out_kept_reg;

endmodule

@@ dv/tb_sop_cover_to_truth_table.sv @@
module tb_sop_cover_to_truth_table;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_AFTER  = 300;   // input words accepted before the long hold-off
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_TAIL  = 8;     // settle margin after draining
    localparam int WORDS_PHASE = 190;

    // One cover row as it goes onto the input bus
    typedef struct {
        logic [sctt_pkg::COUNT_W-1:0] n;
        logic [sctt_pkg::CUBE_W-1:0]  care;
        logic [sctt_pkg::CUBE_W-1:0]  val;
        logic                         oz;
        logic                         first_row;
        logic                         last_row;
        logic                         has_row;
    } row_word_t;

    // One finished gate
    typedef struct {
        logic [sctt_pkg::TABLE_W-1:0] tt;
        logic                         kept;
    } gate_result_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [sctt_pkg::COUNT_W-1:0]   cfg_wdata = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [sctt_pkg::S_TDATA_W-1:0] s_tdata   = '0;
    logic [sctt_pkg::S_TUSER_W-1:0] s_tuser   = '0;
    logic                           s_tlast   = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [sctt_pkg::TABLE_W-1:0]   m_tdata;
    logic                           m_tuser;

    sop_cover_to_truth_table u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #(CLK_HALF) aclk = ~aclk;

    row_word_t    row_q[$];
    gate_result_t tt_expect_q[$];

    int send_idle_pct = 6;
    int recv_idle_pct = 88;
    int in_words      = 0;
    int mismatches    = 0;
    int cycles        = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;

    // Shadow of the gate under construction
    logic [sctt_pkg::TABLE_W-1:0] acc_tt     = '0;
    logic                         acc_cover0 = 1'b0;
    logic [sctt_pkg::COUNT_W-1:0] acc_n      = '0;
    logic                         acc_seen   = 1'b0;
    logic [sctt_pkg::COUNT_W-1:0] lim_inputs =
        sctt_pkg::COUNT_W'(sctt_pkg::MAX_GATE_INPUTS);

    // Minterms hit by a cube, positions at or beyond n treated as dashes
    function automatic logic [sctt_pkg::TABLE_W-1:0] cube_cover(
            input logic [sctt_pkg::COUNT_W-1:0] n,
            input logic [sctt_pkg::CUBE_W-1:0]  care,
            input logic [sctt_pkg::CUBE_W-1:0]  val);
        logic [sctt_pkg::CUBE_W-1:0]  live;
        logic [sctt_pkg::TABLE_W-1:0] hits;
        live = (n >= sctt_pkg::COUNT_W'(6)) ? '1 : sctt_pkg::CUBE_W'((7'd1 << n) - 7'd1);
        for (int m = 0; m < sctt_pkg::TABLE_W; m++) begin
            hits[m] = (((sctt_pkg::CUBE_W'(m) ^ val) & care & live) == '0);
        end
        return hits;
    endfunction

    function automatic logic [sctt_pkg::TABLE_W-1:0] live_minterms(
            input logic [sctt_pkg::COUNT_W-1:0] n);
        if (n >= sctt_pkg::COUNT_W'(6)) begin
            return '1;
        end
        return (64'd1 << (64'd1 << n)) - 64'd1;
    endfunction

    // Fold one accepted row into the shadow gate; queue the gate on its last row
    task automatic fold_row(input row_word_t r);
        gate_result_t g;
        if (r.first_row) begin
            acc_n      = r.n;
            acc_tt     = '0;
            acc_cover0 = 1'b0;
            acc_seen   = 1'b0;
        end
        if (r.has_row) begin
            if (!acc_seen) begin
                acc_cover0 = r.oz;
                acc_tt     = r.oz ? '1 : '0;
                acc_seen   = 1'b1;
            end
            if (acc_cover0) begin
                acc_tt &= ~cube_cover(acc_n, r.care, r.val);
            end else begin
                acc_tt |= cube_cover(acc_n, r.care, r.val);
            end
        end
        if (r.last_row) begin
            g.kept = (acc_n <= lim_inputs) &&
                     (acc_n <= sctt_pkg::COUNT_W'(sctt_pkg::MAX_GATE_INPUTS));
            g.tt   = (g.kept && acc_seen) ? (acc_tt & live_minterms(acc_n)) : '0;
            tt_expect_q = {tt_expect_q, g};
            acc_tt     = '0;
            acc_cover0 = 1'b0;
            acc_seen   = 1'b0;
        end
    endtask

    // Cycle count and timeout
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Input driver: next row from the queue, with random gaps
    always @(posedge aclk) begin
        row_word_t r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (row_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                r = row_q.pop_front();
                s_tdata  <= {r.oz, r.val, r.care, r.n};
                s_tuser  <= {r.has_row, r.first_row};
                s_tlast  <= r.last_row;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result ready: random stalls plus one long hold-off
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (!hold_done && in_words >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: check results against the oldest expectation, then predict
    always @(posedge aclk) begin
        gate_result_t g;
        row_word_t    r;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (tt_expect_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result word: tt=%h kept=%b", m_tdata, m_tuser);
                    end
                end else begin
                    g = tt_expect_q.pop_front();
                    if (m_tdata !== g.tt || m_tuser !== g.kept) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result mismatch: tt exp %h got %h, kept exp %b got %b",
                                     g.tt, m_tdata, g.kept, m_tuser);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                r.n         = s_tdata[2:0];
                r.care      = s_tdata[8:3];
                r.val       = s_tdata[14:9];
                r.oz        = s_tdata[15];
                r.first_row = s_tuser[sctt_pkg::TUSER_FIRST];
                r.has_row   = s_tuser[sctt_pkg::TUSER_HAS];
                r.last_row  = s_tlast;
                in_words <= in_words + 1;
                fold_row(r);
            end
        end
    end

    task automatic put_row(input logic [sctt_pkg::COUNT_W-1:0] n,
                           input logic [sctt_pkg::CUBE_W-1:0] care,
                           input logic [sctt_pkg::CUBE_W-1:0] val, input logic oz,
                           input logic first_row, input logic last_row,
                           input logic has_row);
        row_word_t r;
        r.n = n; r.care = care; r.val = val; r.oz = oz;
        r.first_row = first_row; r.last_row = last_row; r.has_row = has_row;
        row_q = {row_q, r};
    endtask

    // One random gate, or now and then a stray word with every bit random
    task automatic add_gate(inout int left);
        row_word_t r;
        int        rows;
        int        words;
        logic      pol;
        logic [sctt_pkg::COUNT_W-1:0] n;
        if ($urandom_range(0, 99) < 12) begin
            r.n         = sctt_pkg::COUNT_W'($urandom);
            r.care      = sctt_pkg::CUBE_W'($urandom);
            r.val       = sctt_pkg::CUBE_W'($urandom);
            r.oz        = 1'($urandom);
            r.first_row = 1'($urandom);
            r.last_row  = 1'($urandom);
            r.has_row   = 1'($urandom);
            row_q = {row_q, r};
            left--;
            return;
        end
        n     = sctt_pkg::COUNT_W'($urandom_range(0, 7));
        rows  = $urandom_range(0, 6);
        words = (rows == 0) ? 1 : rows;
        pol   = 1'($urandom);
        for (int k = 0; k < words; k++) begin
            r.first_row = (k == 0);
            r.last_row  = (k == words - 1);
            r.has_row   = (rows == 0) ? 1'b0 : ($urandom_range(0, 9) != 0);
            r.n         = (k == 0) ? n : sctt_pkg::COUNT_W'($urandom);
            // sparse care masks give cubes that cover several minterms
            r.care      = ($urandom_range(0, 3) == 0) ? sctt_pkg::CUBE_W'($urandom)
                                                       : sctt_pkg::CUBE_W'($urandom & $urandom);
            r.val       = sctt_pkg::CUBE_W'($urandom);
            r.oz        = (k == 0) ? pol : 1'($urandom);
            row_q = {row_q, r};
        end
        left -= words;
    endtask

    // Block is idle: nothing queued, nothing in flight, nothing owed
    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (row_q.size() != 0 || s_tvalid || tt_expect_q.size() != 0);
        repeat (DRAIN_TAIL) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [sctt_pkg::COUNT_W-1:0] v);
        @(posedge aclk);
        cfg_we     <= 1'b1;
        cfg_wdata  <= v;
        lim_inputs  = v;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Stimulus sequence
    initial begin
        logic [sctt_pkg::COUNT_W-1:0] limits[8];
        int left;
        limits = '{3'd0, 3'd7, 3'd3, 3'd6, 3'd2, 3'd5, 3'd1, 3'd4};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed gates under the reset limit
        // cover-1, full width, two single minterms
        put_row(3'd6, 6'h3F, 6'h3F, 1'b0, 1'b1, 1'b0, 1'b1);
        put_row(3'd0, 6'h3F, 6'h00, 1'b1, 1'b0, 1'b1, 1'b1);
        // zero inputs: every care position ignored
        put_row(3'd0, 6'h3F, 6'h3F, 1'b0, 1'b1, 1'b1, 1'b1);
        // empty cover
        put_row(3'd3, 6'h15, 6'h2A, 1'b1, 1'b1, 1'b1, 1'b0);
        // seven inputs: dropped whatever the limit
        put_row(3'd7, 6'h01, 6'h01, 1'b1, 1'b1, 1'b0, 1'b1);
        put_row(3'd7, 6'h3F, 6'h00, 1'b0, 1'b0, 1'b1, 1'b1);
        // cover-0, later output column ignored, trailing word without cube
        put_row(3'd4, 6'h03, 6'h01, 1'b1, 1'b1, 1'b0, 1'b1);
        put_row(3'd0, 6'h0C, 6'h0C, 1'b0, 1'b0, 1'b0, 1'b1);
        put_row(3'd0, 6'h00, 6'h00, 1'b0, 1'b0, 1'b1, 1'b0);
        // gate with no opening word keeps the previous input count
        put_row(3'd1, 6'h02, 6'h00, 1'b1, 1'b0, 1'b0, 1'b1);
        put_row(3'd1, 6'h31, 6'h01, 1'b0, 1'b0, 1'b1, 1'b1);
        // polarity comes from the first word that carries a cube
        put_row(3'd3, 6'h00, 6'h00, 1'b0, 1'b1, 1'b0, 1'b0);
        put_row(3'd0, 6'h01, 6'h00, 1'b1, 1'b0, 1'b0, 1'b1);
        put_row(3'd0, 6'h3F, 6'h15, 1'b0, 1'b0, 1'b1, 1'b1);
        // all-dash cube on cover-0 clears everything
        put_row(3'd6, 6'h00, 6'h3F, 1'b1, 1'b1, 1'b1, 1'b1);
        // five inputs: top position ignored
        put_row(3'd5, 6'h20, 6'h20, 1'b0, 1'b1, 1'b0, 1'b1);
        put_row(3'd0, 6'h00, 6'h00, 1'b0, 1'b0, 1'b1, 1'b0);
        // gate reopened before its last word
        put_row(3'd3, 6'h07, 6'h05, 1'b0, 1'b1, 1'b0, 1'b1);
        put_row(3'd2, 6'h3F, 6'h2A, 1'b1, 1'b1, 1'b0, 1'b1);
        put_row(3'd0, 6'h01, 6'h01, 1'b0, 1'b0, 1'b1, 1'b1);
        // one and two inputs
        put_row(3'd1, 6'h01, 6'h00, 1'b0, 1'b1, 1'b1, 1'b1);
        put_row(3'd2, 6'h02, 6'h02, 1'b1, 1'b1, 1'b1, 1'b1);
        wait_drained();

        // Random phases over the limit settings
        for (int p = 0; p < 8; p++) begin
            write_limit(limits[p]);
            @(negedge aclk);
            if (p < 3) begin
                send_idle_pct = 6;
                recv_idle_pct = 88;
            end else if (p < 6) begin
                send_idle_pct = 88;
                recv_idle_pct = 6;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            left = WORDS_PHASE;
            while (left > 0) begin
                add_gate(left);
            end
            wait_drained();
        end

        if (mismatches == 0 && tt_expect_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
